[rtl/core/aes128_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// AES-128 package
// Payload types, register addresses, S-box and GF(2^8) helpers.
// ----------------------------------------------------------------------------
package aes128_pkg;

	localparam int NumRounds = 10;
	localparam int AddrW = 4;

	localparam logic [AddrW-1:0] ADDR_KEY_HIGH = 4'h0;
	localparam logic [AddrW-1:0] ADDR_KEY_LOW  = 4'h8;

	typedef struct packed {
		logic [63:0] plain_high;
		logic [63:0] plain_low;
	} aes_in_t;

	typedef struct packed {
		logic [63:0] cipher_high;
		logic [63:0] cipher_low;
	} aes_out_t;

	localparam logic [7:0] SBOX [256] = '{
		8'h63,8'h7C,8'h77,8'h7B,8'hF2,8'h6B,8'h6F,8'hC5,8'h30,8'h01,8'h67,8'h2B,8'hFE,8'hD7,8'hAB,8'h76,
		8'hCA,8'h82,8'hC9,8'h7D,8'hFA,8'h59,8'h47,8'hF0,8'hAD,8'hD4,8'hA2,8'hAF,8'h9C,8'hA4,8'h72,8'hC0,
		8'hB7,8'hFD,8'h93,8'h26,8'h36,8'h3F,8'hF7,8'hCC,8'h34,8'hA5,8'hE5,8'hF1,8'h71,8'hD8,8'h31,8'h15,
		8'h04,8'hC7,8'h23,8'hC3,8'h18,8'h96,8'h05,8'h9A,8'h07,8'h12,8'h80,8'hE2,8'hEB,8'h27,8'hB2,8'h75,
		8'h09,8'h83,8'h2C,8'h1A,8'h1B,8'h6E,8'h5A,8'hA0,8'h52,8'h3B,8'hD6,8'hB3,8'h29,8'hE3,8'h2F,8'h84,
		8'h53,8'hD1,8'h00,8'hED,8'h20,8'hFC,8'hB1,8'h5B,8'h6A,8'hCB,8'hBE,8'h39,8'h4A,8'h4C,8'h58,8'hCF,
		8'hD0,8'hEF,8'hAA,8'hFB,8'h43,8'h4D,8'h33,8'h85,8'h45,8'hF9,8'h02,8'h7F,8'h50,8'h3C,8'h9F,8'hA8,
		8'h51,8'hA3,8'h40,8'h8F,8'h92,8'h9D,8'h38,8'hF5,8'hBC,8'hB6,8'hDA,8'h21,8'h10,8'hFF,8'hF3,8'hD2,
		8'hCD,8'h0C,8'h13,8'hEC,8'h5F,8'h97,8'h44,8'h17,8'hC4,8'hA7,8'h7E,8'h3D,8'h64,8'h5D,8'h19,8'h73,
		8'h60,8'h81,8'h4F,8'hDC,8'h22,8'h2A,8'h90,8'h88,8'h46,8'hEE,8'hB8,8'h14,8'hDE,8'h5E,8'h0B,8'hDB,
		8'hE0,8'h32,8'h3A,8'h0A,8'h49,8'h06,8'h24,8'h5C,8'hC2,8'hD3,8'hAC,8'h62,8'h91,8'h95,8'hE4,8'h79,
		8'hE7,8'hC8,8'h37,8'h6D,8'h8D,8'hD5,8'h4E,8'hA9,8'h6C,8'h56,8'hF4,8'hEA,8'h65,8'h7A,8'hAE,8'h08,
		8'hBA,8'h78,8'h25,8'h2E,8'h1C,8'hA6,8'hB4,8'hC6,8'hE8,8'hDD,8'h74,8'h1F,8'h4B,8'hBD,8'h8B,8'h8A,
		8'h70,8'h3E,8'hB5,8'h66,8'h48,8'h03,8'hF6,8'h0E,8'h61,8'h35,8'h57,8'hB9,8'h86,8'hC1,8'h1D,8'h9E,
		8'hE1,8'hF8,8'h98,8'h11,8'h69,8'hD9,8'h8E,8'h94,8'h9B,8'h1E,8'h87,8'hE9,8'hCE,8'h55,8'h28,8'hDF,
		8'h8C,8'hA1,8'h89,8'h0D,8'hBF,8'hE6,8'h42,8'h68,8'h41,8'h99,8'h2D,8'h0F,8'hB0,8'h54,8'hBB,8'h16
	};

	function automatic logic [7:0] xtime(input logic [7:0] b);
		xtime = {b[6:0], 1'b0} ^ (b[7] ? 8'h1B : 8'h00);
	endfunction

	// byte i of a block sits at bits 127-8i
	function automatic logic [7:0] get_byte(input logic [127:0] v, input int i);
		get_byte = v[127-8*i -: 8];
	endfunction

endpackage
`default_nettype wire

[rtl/core/aes128_round_cell.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// AES-128 round cell
// One cipher round plus the matching key-schedule step, registered.
// ----------------------------------------------------------------------------
module aes128_round_cell (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         en,
	input  wire logic         last,
	input  wire logic [7:0]   rcon,
	input  wire logic         vld_in,
	input  wire logic [127:0] state_in,
	input  wire logic [127:0] key_in,
	output logic              vld_q,
	output logic [127:0]      state_q,
	output logic [127:0]      key_q
);
	import aes128_pkg::*;

	logic [7:0]   sb [16];
	logic [7:0]   mc [16];
	logic [127:0] nkey;
	logic [127:0] nstate;
	logic [31:0]  tw;

	always_comb begin
		// SubBytes with ShiftRows
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				sb[r+4*c] = SBOX[get_byte(state_in, r + 4*((c + r) & 3))];
			end
		end
		for (int c = 0; c < 4; c++) begin
			logic [7:0] all;
			all = sb[4*c] ^ sb[4*c+1] ^ sb[4*c+2] ^ sb[4*c+3];
			mc[4*c]   = sb[4*c]   ^ all ^ xtime(sb[4*c]   ^ sb[4*c+1]);
			mc[4*c+1] = sb[4*c+1] ^ all ^ xtime(sb[4*c+1] ^ sb[4*c+2]);
			mc[4*c+2] = sb[4*c+2] ^ all ^ xtime(sb[4*c+2] ^ sb[4*c+3]);
			mc[4*c+3] = sb[4*c+3] ^ all ^ xtime(sb[4*c+3] ^ sb[4*c]);
		end
		tw = {SBOX[get_byte(key_in,13)] ^ rcon, SBOX[get_byte(key_in,14)],
			SBOX[get_byte(key_in,15)], SBOX[get_byte(key_in,12)]};
		nkey[127:96] = key_in[127:96] ^ tw;
		nkey[95:64]  = key_in[95:64] ^ nkey[127:96];
		nkey[63:32]  = key_in[63:32] ^ nkey[95:64];
		nkey[31:0]   = key_in[31:0] ^ nkey[63:32];
		for (int i = 0; i < 16; i++) begin
			nstate[127-8*i -: 8] = (last ? sb[i] : mc[i]) ^ nkey[127-8*i -: 8];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			state_q <= nstate;
			key_q   <= nkey;
		end
	end

endmodule
`default_nettype wire

[rtl/core/aes128_block_encrypt_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// AES-128 block encrypt unit
// Ten round cells in a chain, each carrying state and round key forward.
// ----------------------------------------------------------------------------
// Path from input beat to output valid: input register, then the 10 round cells.
// Throughput: one block per cycle; the chain advances whenever the last cell's
// result is taken or empty, so a stalled output halts the whole chain.
// Reset clears all valid flags and both key registers; data registers unreset.
module aes128_block_encrypt_unit (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire aes128_pkg::aes_in_t   in_data,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output aes128_pkg::aes_out_t       out_data,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [3:0]            paddr,
	input  wire logic [63:0]           pwdata,
	output logic [63:0]                prdata,
	output logic                       pready
);
	import aes128_pkg::*;

	logic [63:0]  key_high_q, key_low_q;
	logic         en;
	logic         vld_s0;
	logic [127:0] st_s0, key_s0;
	logic         vld   [NumRounds+1];
	logic [127:0] st    [NumRounds+1];
	logic [127:0] rk    [NumRounds+1];
	logic [7:0]   rc    [NumRounds];

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_high_q <= '0;
			key_low_q  <= '0;
		end else if (psel && penable && pwrite) begin
			case (paddr)
				ADDR_KEY_HIGH: key_high_q <= pwdata;
				ADDR_KEY_LOW:  key_low_q  <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr)
			ADDR_KEY_HIGH: prdata = key_high_q;
			ADDR_KEY_LOW:  prdata = key_low_q;
			default:       prdata = '0;
		endcase
	end

	assign en       = !vld[NumRounds] || out_ready;
	assign in_ready = en;

	// entry stage: initial AddRoundKey
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s0 <= 1'b0;
		end else if (en) begin
			vld_s0 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			st_s0  <= {in_data.plain_high, in_data.plain_low} ^ {key_high_q, key_low_q};
			key_s0 <= {key_high_q, key_low_q};
		end
	end

	assign vld[0] = vld_s0;
	assign st[0]  = st_s0;
	assign rk[0]  = key_s0;

	always_comb begin
		rc[0] = 8'h01;
		for (int i = 1; i < NumRounds; i++) begin
			rc[i] = xtime(rc[i-1]);
		end
	end

	for (genvar g = 0; g < NumRounds; g++) begin : g_round
		aes128_round_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.last     (g == NumRounds - 1),
			.rcon     (rc[g]),
			.vld_in   (vld[g]),
			.state_in (st[g]),
			.key_in   (rk[g]),
			.vld_q    (vld[g+1]),
			.state_q  (st[g+1]),
			.key_q    (rk[g+1])
		);
	end

	assign out_valid            = vld[NumRounds];
	assign out_data.cipher_high = st[NumRounds][127:64];
	assign out_data.cipher_low  = st[NumRounds][63:0];

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("output beat changed while stalled");
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready == (!out_valid || out_ready))
		else $error("input ready disagrees with chain advance");
	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> vld_s0)
		else $error("accepted beat lost at entry");

endmodule
`default_nettype wire

[bench/aes128_block_encrypt_unit_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AES-128 block encrypt checker
// Watches both beat channels and the register port, predicts each ciphertext
// from its own key copy and compares every output beat in order.
// ----------------------------------------------------------------------------
module aes128_block_encrypt_unit_checker (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	input  wire logic                 in_ready,
	input  wire aes128_pkg::aes_in_t  in_data,
	input  wire logic                 out_valid,
	input  wire logic                 out_ready,
	input  wire aes128_pkg::aes_out_t out_data,
	input  wire logic                 psel,
	input  wire logic                 penable,
	input  wire logic                 pwrite,
	input  wire logic [3:0]           paddr,
	input  wire logic [63:0]          pwdata,
	input  wire logic                 pready,
	output int                        fail_count,
	output int                        pending
);
	import aes128_pkg::*;

	logic [63:0] key_hi_q, key_lo_q;
	aes_out_t    cipher_q[$];

	localparam logic [7:0] SUB [256] = '{
		8'h63,8'h7C,8'h77,8'h7B,8'hF2,8'h6B,8'h6F,8'hC5,8'h30,8'h01,8'h67,8'h2B,8'hFE,8'hD7,8'hAB,8'h76,
		8'hCA,8'h82,8'hC9,8'h7D,8'hFA,8'h59,8'h47,8'hF0,8'hAD,8'hD4,8'hA2,8'hAF,8'h9C,8'hA4,8'h72,8'hC0,
		8'hB7,8'hFD,8'h93,8'h26,8'h36,8'h3F,8'hF7,8'hCC,8'h34,8'hA5,8'hE5,8'hF1,8'h71,8'hD8,8'h31,8'h15,
		8'h04,8'hC7,8'h23,8'hC3,8'h18,8'h96,8'h05,8'h9A,8'h07,8'h12,8'h80,8'hE2,8'hEB,8'h27,8'hB2,8'h75,
		8'h09,8'h83,8'h2C,8'h1A,8'h1B,8'h6E,8'h5A,8'hA0,8'h52,8'h3B,8'hD6,8'hB3,8'h29,8'hE3,8'h2F,8'h84,
		8'h53,8'hD1,8'h00,8'hED,8'h20,8'hFC,8'hB1,8'h5B,8'h6A,8'hCB,8'hBE,8'h39,8'h4A,8'h4C,8'h58,8'hCF,
		8'hD0,8'hEF,8'hAA,8'hFB,8'h43,8'h4D,8'h33,8'h85,8'h45,8'hF9,8'h02,8'h7F,8'h50,8'h3C,8'h9F,8'hA8,
		8'h51,8'hA3,8'h40,8'h8F,8'h92,8'h9D,8'h38,8'hF5,8'hBC,8'hB6,8'hDA,8'h21,8'h10,8'hFF,8'hF3,8'hD2,
		8'hCD,8'h0C,8'h13,8'hEC,8'h5F,8'h97,8'h44,8'h17,8'hC4,8'hA7,8'h7E,8'h3D,8'h64,8'h5D,8'h19,8'h73,
		8'h60,8'h81,8'h4F,8'hDC,8'h22,8'h2A,8'h90,8'h88,8'h46,8'hEE,8'hB8,8'h14,8'hDE,8'h5E,8'h0B,8'hDB,
		8'hE0,8'h32,8'h3A,8'h0A,8'h49,8'h06,8'h24,8'h5C,8'hC2,8'hD3,8'hAC,8'h62,8'h91,8'h95,8'hE4,8'h79,
		8'hE7,8'hC8,8'h37,8'h6D,8'h8D,8'hD5,8'h4E,8'hA9,8'h6C,8'h56,8'hF4,8'hEA,8'h65,8'h7A,8'hAE,8'h08,
		8'hBA,8'h78,8'h25,8'h2E,8'h1C,8'hA6,8'hB4,8'hC6,8'hE8,8'hDD,8'h74,8'h1F,8'h4B,8'hBD,8'h8B,8'h8A,
		8'h70,8'h3E,8'hB5,8'h66,8'h48,8'h03,8'hF6,8'h0E,8'h61,8'h35,8'h57,8'hB9,8'h86,8'hC1,8'h1D,8'h9E,
		8'hE1,8'hF8,8'h98,8'h11,8'h69,8'hD9,8'h8E,8'h94,8'h9B,8'h1E,8'h87,8'hE9,8'hCE,8'h55,8'h28,8'hDF,
		8'h8C,8'hA1,8'h89,8'h0D,8'hBF,8'hE6,8'h42,8'h68,8'h41,8'h99,8'h2D,8'h0F,8'hB0,8'h54,8'hBB,8'h16
	};

	function automatic logic [7:0] gf_dbl(input logic [7:0] b);
		gf_dbl = {b[6:0], 1'b0} ^ (b[7] ? 8'h1B : 8'h00);
	endfunction

	function automatic aes_out_t encrypt_block(input aes_in_t pt, input logic [127:0] key);
		logic [7:0] s [16];
		logic [7:0] t [16];
		logic [7:0] rk [16];
		logic [7:0] k4 [4];
		logic [7:0] rc, a0, a1, a2, a3, all;
		logic [127:0] blk, res;
		aes_out_t o;
		blk = pt;
		rc = 8'h01;
		for (int i = 0; i < 16; i++) begin
			rk[i] = key[127-8*i -: 8];
			s[i] = blk[127-8*i -: 8] ^ rk[i];
		end
		for (int rnd = 1; rnd <= 10; rnd++) begin
			// sub bytes with row shift folded into the index
			for (int c = 0; c < 4; c++)
				for (int r = 0; r < 4; r++)
					t[r + 4*c] = SUB[s[r + 4*((c + r) & 3)]];
			if (rnd != 10) begin
				for (int c = 0; c < 4; c++) begin
					a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
					all = a0 ^ a1 ^ a2 ^ a3;
					t[4*c]   = a0 ^ all ^ gf_dbl(a0 ^ a1);
					t[4*c+1] = a1 ^ all ^ gf_dbl(a1 ^ a2);
					t[4*c+2] = a2 ^ all ^ gf_dbl(a2 ^ a3);
					t[4*c+3] = a3 ^ all ^ gf_dbl(a3 ^ a0);
				end
			end
			k4[0] = SUB[rk[13]] ^ rc;
			k4[1] = SUB[rk[14]];
			k4[2] = SUB[rk[15]];
			k4[3] = SUB[rk[12]];
			for (int i = 0; i < 4; i++) rk[i] = rk[i] ^ k4[i];
			for (int i = 4; i < 16; i++) rk[i] = rk[i] ^ rk[i-4];
			rc = gf_dbl(rc);
			for (int i = 0; i < 16; i++) s[i] = t[i] ^ rk[i];
		end
		for (int i = 0; i < 16; i++) res[127-8*i -: 8] = s[i];
		o = res;
		return o;
	endfunction

	assign pending = cipher_q.size();

	always @(posedge clk or negedge arst_n) begin
		aes_out_t exp_c;
		if (!arst_n) begin
			key_hi_q <= '0;
			key_lo_q <= '0;
			fail_count <= 0;
			cipher_q.delete();
		end else begin
			if (psel && penable && pwrite && pready) begin
				if (paddr == ADDR_KEY_HIGH) key_hi_q <= pwdata;
				else if (paddr == ADDR_KEY_LOW) key_lo_q <= pwdata;
			end
			if (in_valid && in_ready)
				cipher_q.push_back(encrypt_block(in_data, {key_hi_q, key_lo_q}));
			if (out_valid && out_ready) begin
				if (cipher_q.size() == 0) begin
					$display("%0t: unexpected beat %h", $time, out_data);
					fail_count <= fail_count + 1;
				end else begin
					exp_c = cipher_q.pop_front();
					if (exp_c.cipher_high !== out_data.cipher_high ||
							exp_c.cipher_low !== out_data.cipher_low) begin
						$display("%0t: mismatch expected %h_%h actual %h_%h", $time,
							exp_c.cipher_high, exp_c.cipher_low,
							out_data.cipher_high, out_data.cipher_low);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end
endmodule

[bench/aes128_block_encrypt_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AES-128 block encrypt testbench
// Writes several keys over the register port, streams directed and random
// plaintext beats under varied back-pressure and leaves checking to the checker.
// ----------------------------------------------------------------------------
module aes128_block_encrypt_unit_tb;
	import aes128_pkg::*;

	localparam int IdleLimit = 2000;
	localparam int PipeDepth = 11;

	logic        clk, arst_n;
	logic        in_valid, in_ready, out_valid, out_ready;
	aes_in_t     in_data;
	aes_out_t    out_data;
	logic        psel, penable, pwrite, pready;
	logic [3:0]  paddr;
	logic [63:0] pwdata, prdata;
	int          fail_count, pending;
	int          send_idle_pct, sink_stall_pct;
	int          quiet_cycles;

	aes128_block_encrypt_unit u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	aes128_block_encrypt_unit_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .pready(pready),
		.fail_count(fail_count), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// receiver back-pressure
	always @(posedge clk) out_ready <= ($urandom_range(99) >= sink_stall_pct);

	// watchdog on beat activity
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || psel)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= IdleLimit) begin
			$display("aes128_block_encrypt_unit test failed");
			$finish;
		end
	end

	task automatic reg_write(input logic [3:0] addr, input logic [63:0] val);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_block(input logic [63:0] hi, input logic [63:0] lo);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= '{plain_high: hi, plain_low: lo};
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	task automatic drain_pipe();
		in_valid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (PipeDepth + 4) @(posedge clk);
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	function automatic logic [63:0] edge_word();
		case ($urandom_range(5))
			0: return 64'h0;
			1: return '1;
			2: return 64'h1 << $urandom_range(63);
			3: return ~(64'h1 << $urandom_range(63));
			default: return rand64();
		endcase
	endfunction

	initial begin
		logic [63:0] hi, lo;
		arst_n = 1'b0;
		in_valid = 1'b0; in_data = '0; out_ready = 1'b0;
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		send_idle_pct = 0; sink_stall_pct = 0; quiet_cycles = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset key of zero, then FIPS-197 appendix key
		send_block(64'h0, 64'h0);
		send_block('1, '1);
		send_block(64'h0011223344556677, 64'h8899AABBCCDDEEFF);
		drain_pipe();
		reg_write(ADDR_KEY_HIGH, 64'h0001020304050607);
		reg_write(ADDR_KEY_LOW,  64'h08090A0B0C0D0E0F);
		send_block(64'h0011223344556677, 64'h8899AABBCCDDEEFF);
		send_block(64'h0, 64'h0);
		send_block('1, '1);
		for (int i = 0; i < 8; i++) send_block(64'h1 << (8*i), 64'h80 << (8*i));
		drain_pipe();
		reg_write(ADDR_KEY_HIGH, '1);
		reg_write(ADDR_KEY_LOW, '1);
		send_block(64'h0, 64'h0);
		send_block('1, '1);
		send_block(64'hAAAAAAAAAAAAAAAA, 64'h5555555555555555);
		drain_pipe();

		for (int ph = 0; ph < 8; ph++) begin
			case (ph % 4)
				0: begin send_idle_pct = 0;  sink_stall_pct = 0;  end
				1: begin send_idle_pct = 50; sink_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  sink_stall_pct = 50; end
				default: begin send_idle_pct = 24; sink_stall_pct = 24; end
			endcase
			reg_write(ADDR_KEY_HIGH, (ph == 4) ? 64'h0 : edge_word());
			reg_write(ADDR_KEY_LOW, (ph == 4) ? 64'h0 : edge_word());
			for (int n = 0; n < 200; n++) begin
				hi = ($urandom_range(9) == 0) ? edge_word() : rand64();
				lo = ($urandom_range(9) == 0) ? edge_word() : rand64();
				send_block(hi, lo);
			end
			drain_pipe();
		end

		if (fail_count == 0)
			$display("aes128_block_encrypt_unit test passed");
		else
			$display("aes128_block_encrypt_unit test failed");
		$finish;
	end
endmodule
